// File: design/block_code_hard_decision_decoder_assert.svh
// Assertion macros used by the block code decoder top level.
`ifndef BLOCK_CODE_HARD_DECISION_DECODER_ASSERT_SVH
`define BLOCK_CODE_HARD_DECISION_DECODER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define BCHD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bchd assertion failed");

// Implication checked in the next cycle, outside reset.
`define BCHD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bchd assertion failed");

`endif

// File: design/bchd_pkg.sv
// Package with the codeword table, chain types and distance helper.
package bchd_pkg;

    localparam int CODE_COUNT = 64;
    localparam int CODE_BITS  = 32;
    localparam int IDX_W      = 6;
    localparam int DIST_W     = 6;
    localparam int CELL_COUNT = CODE_COUNT - 1;

    // Larger than any real distance, so the first cell always takes over.
    localparam logic [DIST_W-1:0] DIST_INIT = DIST_W'(CODE_BITS + 1);
    localparam logic [IDX_W-1:0]  IDX_FIRST = IDX_W'(1);

    localparam logic [CODE_BITS-1:0] CODE_TABLE [CODE_COUNT] = '{
        32'h00000000, 32'hA962A941, 32'h26C954C2, 32'h8FABFD83,
        32'h49B23384, 32'hE0D09AC5, 32'h6F7B6746, 32'hC619CE07,
        32'h468D1548, 32'hEFEFBC09, 32'h6044418A, 32'hC926E8CB,
        32'h0F3F26CC, 32'hA65D8F8D, 32'h29F6720E, 32'h8094DB4F,
        32'h9566AA90, 32'h3C0403D1, 32'hB3AFFE52, 32'h1ACD5713,
        32'hDCD49914, 32'h75B63055, 32'hFA1DCDD6, 32'h537F6497,
        32'hD3EBBFD8, 32'h7A891699, 32'hF522EB1A, 32'h5C40425B,
        32'h9A598C5C, 32'h333B251D, 32'hBC90D89E, 32'h15F271DF,
        32'h8D5A49E0, 32'h2438E0A1, 32'hAB931D22, 32'h02F1B463,
        32'hC4E87A64, 32'h6D8AD325, 32'hE2212EA6, 32'h4B4387E7,
        32'hCBD75CA8, 32'h62B5F5E9, 32'hED1E086A, 32'h447CA12B,
        32'h82656F2C, 32'h2B07C66D, 32'hA4AC3BEE, 32'h0DCE92AF,
        32'h183CE370, 32'hB15E4A31, 32'h3EF5B7B2, 32'h97971EF3,
        32'h518ED0F4, 32'hF8EC79B5, 32'h77478436, 32'hDE252D77,
        32'h5EB1F638, 32'hF7D35F79, 32'h7878A2FA, 32'hD11A0BBB,
        32'h1703C5BC, 32'hBE616CFD, 32'h31CA917E, 32'h98A8383F
    };

    typedef struct packed {
        logic [CODE_BITS-1:0] word;
        logic [DIST_W-1:0]    least;
        logic [IDX_W-1:0]     idx;
    } stage_t;

    // Population count: nibble counts in parallel, then their sum.
    function automatic logic [DIST_W-1:0] ones_count(input logic [CODE_BITS-1:0] v);
        logic [2:0]        nib;
        logic [DIST_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < CODE_BITS / 4; i++) begin
            nib = {2'b00, v[4*i]} + {2'b00, v[4*i+1]} + {2'b00, v[4*i+2]}
                + {2'b00, v[4*i+3]};
            sum = sum + DIST_W'(nib);
        end
        return sum;
    endfunction

endpackage

// File: design/bchd_cell.sv
// One distance cell: compares the item's word with one codeword and keeps the best so far.
module bchd_cell
    import bchd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic [CODE_BITS-1:0] code,
    input  logic [IDX_W-1:0]     code_idx,
    input  logic                 vld_in,
    input  stage_t               stage_in,
    output logic                 vld_out,
    output stage_t               stage_out
);

    logic              vld_reg;
    stage_t            stage_reg;
    stage_t            stage_next;
    logic [DIST_W-1:0] hamming;

    // Strict compare keeps the lower index on a tie.
    always_comb
    begin
        hamming         = ones_count(stage_in.word ^ code);
        stage_next      = stage_in;
        if (hamming < stage_in.least)
        begin
            stage_next.least = hamming;
            stage_next.idx   = code_idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg <= vld_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg <= stage_next;
        end
    end

    assign vld_out   = vld_reg;
    assign stage_out = stage_reg;

endmodule

// File: design/bchd_out_stage.sv
// Output register with a skid slot, so the chain keeps moving while a result waits.
module bchd_out_stage
    import bchd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push_vld,
    input  logic [CODE_BITS-1:0] push_data,
    output logic                 ready,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CODE_BITS-1:0] m_tdata
);

    logic                 out_vld_reg;
    logic                 out_vld_next;
    logic [CODE_BITS-1:0] out_data_reg;
    logic                 skid_vld_reg;
    logic                 skid_vld_next;
    logic [CODE_BITS-1:0] skid_data_reg;
    logic                 load_out;
    logic                 load_skid;
    logic                 from_skid;

    assign ready = !skid_vld_reg;

    always_comb
    begin
        load_out      = 1'b0;
        load_skid     = 1'b0;
        from_skid     = 1'b0;
        out_vld_next  = out_vld_reg;
        skid_vld_next = skid_vld_reg;
        if (!skid_vld_reg)
        begin
            if (!out_vld_reg || m_tready)
            begin
                load_out     = 1'b1;
                out_vld_next = push_vld;
            end
            else if (push_vld)
            begin
                load_skid     = 1'b1;
                skid_vld_next = 1'b1;
            end
        end
        else if (m_tready)
        begin
            from_skid     = 1'b1;
            skid_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            skid_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg  <= out_vld_next;
            skid_vld_reg <= skid_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_data_reg <= push_data;
        end
        else if (from_skid)
        begin
            out_data_reg <= skid_data_reg;
        end
        if (load_skid)
        begin
            skid_data_reg <= push_data;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

endmodule

// File: design/block_code_hard_decision_decoder.sv
// Hard-decision decoder for a fixed [32,6] block code: top level with the cell chain.
//
// Input channel s_*: one received 32-bit word per item in s_tdata.
// Output channel m_*: the nearest nonzero codeword per item in m_tdata; ties go
// to the lowest message index. Every input item gives exactly one result item.
// The word passes a row of 63 cells, one per nonzero codeword. Each cell adds one
// Hamming distance compare and is one register stage; an accepted item runs
// through the 63 cells and then the output register before m_tvalid.
// Throughput is one item per cycle while the receiver does not stall; the cell
// chain and the output register are fully pipelined.
// When the receiver stalls, the output register holds its item and one more
// result drops into a skid slot; s_tready then falls and the whole chain freezes
// until the receiver takes the waiting item.
// Reset clears all valid bits; the block is ready to accept items as soon as
// reset is released.
module block_code_hard_decision_decoder
    import bchd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CODE_BITS-1:0] s_tdata,   // [31:0] received_word
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [CODE_BITS-1:0] m_tdata    // [31:0] decoded_word
);

    logic                 chain_vld   [CELL_COUNT+1];
    stage_t               chain_stage [CELL_COUNT+1];
    logic                 adv;
    logic [CODE_BITS-1:0] best_code;

    assign s_tready = adv;

    assign chain_vld[0]         = s_tvalid;
    assign chain_stage[0].word  = s_tdata;
    assign chain_stage[0].least = DIST_INIT;
    assign chain_stage[0].idx   = IDX_FIRST;

    for (genvar k = 1; k <= CELL_COUNT; k++)
    begin : g_cell
        bchd_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .code      (CODE_TABLE[k]),
            .code_idx  (IDX_W'(k)),
            .vld_in    (chain_vld[k-1]),
            .stage_in  (chain_stage[k-1]),
            .vld_out   (chain_vld[k]),
            .stage_out (chain_stage[k])
        );
    end

    assign best_code = CODE_TABLE[chain_stage[CELL_COUNT].idx];

    bchd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_vld  (chain_vld[CELL_COUNT]),
        .push_data (best_code),
        .ready     (adv),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

`include "block_code_hard_decision_decoder_assert.svh"

    // The all-zero codeword is never a result.
    `BCHD_ASSERT_NOW(a_nonzero_out, m_tvalid, m_tdata != '0)
    // The input side only stalls after the receiver left a result waiting.
    `BCHD_ASSERT_NOW(a_stall_cause, !s_tready, $past(m_tvalid && !m_tready))
    // A full skid slot with a taking receiver frees the input side next cycle.
    `BCHD_ASSERT_NEXT(a_skid_drain, !s_tready && m_tready, s_tready && m_tvalid)

endmodule
